FILE: rtl/core/tpbf_pkg.sv
// ----------------------------------------------------------------------------
// tpbf_pkg
// Shared types, constants and the control program of the two-pole band-pass
// filter sequencer.
// ----------------------------------------------------------------------------
package tpbf_pkg;

    localparam int COEF_WIDTH = 32;   // Q3.28 coefficients
    localparam int COEF_FRAC  = 28;
    localparam int SPLIT      = 24;   // state is multiplied as hi/lo halves
    localparam int OPND_W     = SPLIT + 1;
    localparam int STEP_W     = 4;
    localparam int ADDR_W     = 4;

    typedef logic [STEP_W-1:0] t_step;

    localparam t_step STEP_IDLE = 4'd0;

    typedef enum logic [1:0] {
        REG_COEF_ONE = 2'd0,
        REG_COEF_TWO = 2'd1,
        REG_GAIN     = 2'd2,
        REG_NONE     = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        COEF_A1   = 2'd0,
        COEF_A2   = 2'd1,
        COEF_GAIN = 2'd2
    } t_coef_sel;

    typedef enum logic [1:0] {
        OPND_RECENT_LO = 2'd0,
        OPND_RECENT_HI = 2'd1,
        OPND_OLDER_LO  = 2'd2,
        OPND_OLDER_HI  = 2'd3
    } t_opnd_sel;

    typedef enum logic [1:0] {
        ACC_HOLD = 2'd0,
        ACC_LOAD = 2'd1,
        ACC_ADD  = 2'd2
    } t_acc_op;

    // One control word per program step.
    typedef struct packed {
        t_coef_sel coef;       // multiplier coefficient operand
        t_opnd_sel opnd;       // multiplier state operand (half word)
        t_acc_op   acc_op;     // what to do with last cycle's product
        logic      acc_shift;  // product belongs to a high half
        logic      take_in;    // ready for a new beat; hold here until one comes
        logic      fb_update;  // close the recursion, shift the state
        logic      put_out;    // load the output register; hold while it is full
        logic      jump;       // go to target instead of the next step
        t_step     target;
    } t_ucode;

    function automatic t_ucode mk(input t_coef_sel coef, input t_opnd_sel opnd,
                                  input t_acc_op acc_op, input logic acc_shift,
                                  input logic take_in, input logic fb_update,
                                  input logic put_out, input logic jump,
                                  input t_step target);
        t_ucode w;
        w.coef      = coef;
        w.opnd      = opnd;
        w.acc_op    = acc_op;
        w.acc_shift = acc_shift;
        w.take_in   = take_in;
        w.fb_update = fb_update;
        w.put_out   = put_out;
        w.jump      = jump;
        w.target    = target;
        return w;
    endfunction

    // Program ROM. The multiplier result is registered, so each word
    // accumulates the product issued by the word before it.
    function automatic t_ucode ucode(input t_step step);
        t_ucode w;
        case (step)
            4'd0: w = mk(COEF_A1,   OPND_RECENT_LO, ACC_HOLD, 1'b0,
                         1'b1, 1'b0, 1'b0, 1'b0, STEP_IDLE);
            4'd1: w = mk(COEF_A1,   OPND_RECENT_HI, ACC_LOAD, 1'b0,
                         1'b0, 1'b0, 1'b0, 1'b0, STEP_IDLE);
            4'd2: w = mk(COEF_A2,   OPND_OLDER_LO,  ACC_ADD,  1'b1,
                         1'b0, 1'b0, 1'b0, 1'b0, STEP_IDLE);
            4'd3: w = mk(COEF_A2,   OPND_OLDER_HI,  ACC_ADD,  1'b0,
                         1'b0, 1'b0, 1'b0, 1'b0, STEP_IDLE);
            4'd4: w = mk(COEF_A2,   OPND_OLDER_HI,  ACC_ADD,  1'b1,
                         1'b0, 1'b0, 1'b0, 1'b0, STEP_IDLE);
            4'd5: w = mk(COEF_GAIN, OPND_RECENT_LO, ACC_HOLD, 1'b0,
                         1'b0, 1'b1, 1'b0, 1'b0, STEP_IDLE);
            // recent now holds the new feedback value
            4'd6: w = mk(COEF_GAIN, OPND_RECENT_LO, ACC_HOLD, 1'b0,
                         1'b0, 1'b0, 1'b0, 1'b0, STEP_IDLE);
            4'd7: w = mk(COEF_GAIN, OPND_RECENT_HI, ACC_LOAD, 1'b0,
                         1'b0, 1'b0, 1'b0, 1'b0, STEP_IDLE);
            4'd8: w = mk(COEF_GAIN, OPND_RECENT_HI, ACC_ADD,  1'b1,
                         1'b0, 1'b0, 1'b0, 1'b0, STEP_IDLE);
            4'd9: w = mk(COEF_GAIN, OPND_RECENT_LO, ACC_HOLD, 1'b0,
                         1'b0, 1'b0, 1'b1, 1'b1, STEP_IDLE);
            default: w = mk(COEF_A1, OPND_RECENT_LO, ACC_HOLD, 1'b0,
                            1'b0, 1'b0, 1'b0, 1'b1, STEP_IDLE);
        endcase
        return w;
    endfunction

endpackage

FILE: rtl/core/two_pole_bandpass_filter.sv
// ----------------------------------------------------------------------------
// two_pole_bandpass_filter
// Two-pole band-pass resonator: f = x + a1*f[n-1] + a2*f[n-2], y = gain*f,
// run by a small microcoded sequencer around one shared multiplier.
// ----------------------------------------------------------------------------
// A sample beat is accepted at the idle step and the program then runs to the
// end, where the result is loaded into the output register; no new beat is
// taken in before that. The program length is set by the single 32 x 25 bit
// multiplier: the state words are split into a high and a low half, giving six
// products per sample (two per coefficient), each registered before it is
// accumulated, plus one step to close the recursion and one to load the
// output. The input is ready only at the idle step of the program; a finished
// result waits in the output register while the next beat is taken in.
// Coefficients a1, a2 and gain are signed Q3.28 at byte addresses 0, 4 and 8;
// write them only while the filter is idle. Sums are rounded half up, the
// feedback state saturates to STATE_WIDTH bits and the output to SAMPLE_WIDTH.
// ----------------------------------------------------------------------------
module two_pole_bandpass_filter
    import tpbf_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 24,
    parameter int STATE_WIDTH  = 40
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,

    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_in,

    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] o_sample_out,

    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ADDR_W-1:0]              paddr,
    input  logic [COEF_WIDTH-1:0]          pwdata,
    output logic [COEF_WIDTH-1:0]          prdata,
    output logic                           pready
);

    localparam int ACC_W  = STATE_WIDTH + COEF_WIDTH + 1;
    localparam int PROD_W = COEF_WIDTH + OPND_W;
    localparam int HI_W   = STATE_WIDTH - SPLIT;

    localparam logic signed [ACC_W-1:0] ROUND_HALF =
        {{(ACC_W-COEF_FRAC){1'b0}}, 1'b1, {(COEF_FRAC-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] ST_MAX =
        {{(ACC_W-STATE_WIDTH+1){1'b0}}, {(STATE_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ST_MIN =
        {{(ACC_W-STATE_WIDTH+1){1'b1}}, {(STATE_WIDTH-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] SMP_MAX =
        {{(ACC_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SMP_MIN =
        {{(ACC_W-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};

    // configuration
    logic signed [COEF_WIDTH-1:0] r_coef_one, r_coef_two, r_gain;
    // sequencer and datapath
    t_step                         r_step, n_step;
    t_ucode                        uc;
    logic signed [SAMPLE_WIDTH-1:0] r_x;
    logic signed [STATE_WIDTH-1:0] r_recent, r_older;
    logic signed [PROD_W-1:0]      r_prod;
    logic signed [ACC_W-1:0]       r_acc, n_acc;
    logic                          r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_out;

    logic signed [COEF_WIDTH-1:0]  mul_coef;
    logic signed [OPND_W-1:0]      mul_opnd;
    logic signed [ACC_W-1:0]       prod_ext, prod_al;
    logic signed [ACC_W-1:0]       acc_rnd, fb_sum, x_ext;
    logic signed [STATE_WIDTH-1:0] fb_sat;
    logic signed [SAMPLE_WIDTH-1:0] y_sat;
    logic                          in_beat, out_load;
    t_reg_idx                      reg_idx;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_one <= '0;
            r_coef_two <= '0;
            r_gain     <= 32'sd536870912;
        end else if (psel && penable && pwrite && pready) begin
            case (reg_idx)
                REG_COEF_ONE: r_coef_one <= pwdata;
                REG_COEF_TWO: r_coef_two <= pwdata;
                REG_GAIN:     r_gain     <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_COEF_ONE: prdata = r_coef_one;
            REG_COEF_TWO: prdata = r_coef_two;
            REG_GAIN:     prdata = r_gain;
            default:      prdata = '0;
        endcase
    end

    // ---------------- sequencer ----------------
    assign uc         = ucode(r_step);
    assign o_in_ready = uc.take_in;
    assign in_beat    = i_in_valid && uc.take_in;
    assign out_load   = uc.put_out && (!r_out_valid || i_out_ready);

    always_comb begin
        if (uc.take_in && !i_in_valid) begin
            n_step = r_step;
        end else if (uc.put_out && !out_load) begin
            n_step = r_step;
        end else if (uc.jump) begin
            n_step = uc.target;
        end else begin
            n_step = r_step + t_step'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    // ---------------- multiplier ----------------
    always_comb begin
        case (uc.coef)
            COEF_A1:   mul_coef = r_coef_one;
            COEF_A2:   mul_coef = r_coef_two;
            COEF_GAIN: mul_coef = r_gain;
            default:   mul_coef = r_coef_one;
        endcase
    end

    // low halves are unsigned, high halves carry the sign
    always_comb begin
        case (uc.opnd)
            OPND_RECENT_LO: mul_opnd = {1'b0, r_recent[SPLIT-1:0]};
            OPND_RECENT_HI: mul_opnd = {{(OPND_W-HI_W){r_recent[STATE_WIDTH-1]}},
                                        r_recent[STATE_WIDTH-1:SPLIT]};
            OPND_OLDER_LO:  mul_opnd = {1'b0, r_older[SPLIT-1:0]};
            OPND_OLDER_HI:  mul_opnd = {{(OPND_W-HI_W){r_older[STATE_WIDTH-1]}},
                                        r_older[STATE_WIDTH-1:SPLIT]};
            default:        mul_opnd = {1'b0, r_recent[SPLIT-1:0]};
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(mul_coef) * PROD_W'(mul_opnd);
    end

    // ---------------- accumulator ----------------
    assign prod_ext = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
    assign prod_al  = uc.acc_shift ? (prod_ext <<< SPLIT) : prod_ext;

    always_comb begin
        case (uc.acc_op)
            ACC_LOAD: n_acc = prod_al;
            ACC_ADD:  n_acc = r_acc + prod_al;
            default:  n_acc = r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    // round half up, then saturate
    assign acc_rnd = (r_acc + ROUND_HALF) >>> COEF_FRAC;
    assign x_ext   = {{(ACC_W-SAMPLE_WIDTH){r_x[SAMPLE_WIDTH-1]}}, r_x};
    assign fb_sum  = acc_rnd + x_ext;

    always_comb begin
        if (fb_sum > ST_MAX) begin
            fb_sat = ST_MAX[STATE_WIDTH-1:0];
        end else if (fb_sum < ST_MIN) begin
            fb_sat = ST_MIN[STATE_WIDTH-1:0];
        end else begin
            fb_sat = fb_sum[STATE_WIDTH-1:0];
        end
    end

    always_comb begin
        if (acc_rnd > SMP_MAX) begin
            y_sat = SMP_MAX[SAMPLE_WIDTH-1:0];
        end else if (acc_rnd < SMP_MIN) begin
            y_sat = SMP_MIN[SAMPLE_WIDTH-1:0];
        end else begin
            y_sat = acc_rnd[SAMPLE_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_x <= i_sample_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recent <= '0;
            r_older  <= '0;
        end else if (uc.fb_update) begin
            r_older  <= r_recent;
            r_recent <= fb_sat;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= y_sat;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out;

endmodule
